// File: rtl/bleadv_pkg.sv
package bleadv_pkg;

  typedef enum logic [1:0] {
    PhLen  = 2'd0,
    PhType = 2'd1,
    PhData = 2'd2,
    PhStop = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CfgTargetUuid     = 2'd0,
    CfgListTypeA      = 2'd1,
    CfgListTypeB      = 2'd2,
    CfgAppearanceType = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  AppearMinLen = 8'd3;
  localparam logic [7:0]  AppearIdx    = 8'd1;

  localparam logic [15:0] RstTargetUuid     = 16'h1812;
  localparam logic [7:0]  RstListTypeA      = 8'd3;
  localparam logic [7:0]  RstListTypeB      = 8'd2;
  localparam logic [7:0]  RstAppearanceType = 8'd25;

  typedef struct packed {
    logic [15:0] svc_uuid;
    logic [7:0]  list_type_a;
    logic [7:0]  list_type_b;
    logic [7:0]  appearance_type;
  } cfg_t;

  typedef struct packed {
    logic [15:0] appearance;
    logic        uuid_found;
  } result_t;

endpackage

// File: rtl/ble_adv_structure_parser.sv
// advertising data parser: walks the length-type-data structures of one
// packet and reports the first appearance value and a service uuid hit
//
// input channel: in_valid_i / in_stall_o with data_byte_i and last_byte_i,
// one packet byte per request, last_byte_i set on the final byte
// output channel: out_valid_o / out_stall_i with appearance_o and
// uuid_found_o, one request per packet, issued for its last byte
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 target uuid, 1 and 2 list types, 3 appearance type); write only
// while no packet is in flight
//
// throughput: one byte per cycle, set by the single registered parse step
// latency: result is valid one cycle after the last byte is taken
// (input register, then the parse step into the result register)
// reset clears all parse state and the registers to their defaults
// a stalled result holds; the input keeps flowing until the next last
// byte reaches the parse step while the result is still held
module ble_adv_structure_parser
  import bleadv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         appearance_o,
  output logic                uuid_found_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       adv;
  logic       in_take;
  logic       out_load;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.svc_uuid        <= RstTargetUuid;
      cfg_q.list_type_a     <= RstListTypeA;
      cfg_q.list_type_b     <= RstListTypeB;
      cfg_q.appearance_type <= RstAppearanceType;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTargetUuid:     cfg_q.svc_uuid        <= cfg_data_i;
        CfgListTypeA:      cfg_q.list_type_a     <= cfg_data_i[7:0];
        CfgListTypeB:      cfg_q.list_type_b     <= cfg_data_i[7:0];
        CfgAppearanceType: cfg_q.appearance_type <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // a last byte may only step when the result register is free or draining
  assign adv        = in_valid_q && !(last_q && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_load   = adv && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  bleadv_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign appearance_o = res_q.appearance;
  assign uuid_found_o = res_q.uuid_found;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held result");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("held result overwritten");

  a_load_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> in_valid_q && last_q)
    else $error("result loaded without a last byte");

endmodule

// File: rtl/bleadv_parse_core.sv
module bleadv_parse_core
  import bleadv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  struct_len_q, struct_len_d;
  logic [7:0]  struct_type_q, struct_type_d;
  logic [7:0]  low_half_q, low_half_d;
  logic        pair_phase_q, pair_phase_d;
  logic [15:0] app_pending_q, app_pending_d;
  logic [15:0] app_result_q, app_result_d;
  logic        app_seen_q, app_seen_d;
  logic        uuid_pending_q, uuid_pending_d;
  logic        uuid_result_q, uuid_result_d;

  logic [7:0]  len_m1;
  logic [7:0]  idx;
  logic [7:0]  left_dec;
  logic [15:0] pair_val;
  logic        commit;
  logic [7:0]  cm_type;
  logic        cm_uuid;
  logic [15:0] cm_app;

  assign len_m1   = struct_len_q - 8'd1;
  assign idx      = len_m1 - bytes_left_q;
  assign left_dec = bytes_left_q - 8'd1;
  assign pair_val = {byte_i, low_half_q};

  // structure completes on its type byte (length one) or its last data byte
  always_comb begin
    commit = 1'b0;
    unique case (phase_q)
      PhType:  commit = len_m1 == 8'd0;
      PhData:  commit = left_dec == 8'd0;
      default: commit = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhLen:   phase_d = (byte_i == 8'd0) ? PhStop : PhType;
      PhType:  phase_d = (len_m1 == 8'd0) ? PhLen : PhData;
      PhData:  phase_d = commit ? PhLen : PhData;
      PhStop:  phase_d = PhStop;
      default: phase_d = PhLen;
    endcase
    if (last_i) begin
      phase_d = PhLen;
    end
  end

  // datapath updates
  always_comb begin
    bytes_left_d   = bytes_left_q;
    struct_len_d   = struct_len_q;
    struct_type_d  = struct_type_q;
    low_half_d     = low_half_q;
    pair_phase_d   = pair_phase_q;
    app_pending_d  = app_pending_q;
    app_result_d   = app_result_q;
    app_seen_d     = app_seen_q;
    uuid_pending_d = uuid_pending_q;
    uuid_result_d  = uuid_result_q;
    cm_type        = struct_type_q;
    cm_uuid        = uuid_pending_q;
    cm_app         = app_pending_q;

    unique case (phase_q)
      PhLen: begin
        if (byte_i != 8'd0) begin
          struct_len_d = byte_i;
        end
      end
      PhType: begin
        struct_type_d  = byte_i;
        bytes_left_d   = len_m1;
        pair_phase_d   = 1'b0;
        low_half_d     = 8'd0;
        app_pending_d  = 16'd0;
        uuid_pending_d = 1'b0;
        cm_type        = byte_i;
        cm_uuid        = 1'b0;
        cm_app         = 16'd0;
      end
      PhData: begin
        bytes_left_d = left_dec;
        if (!pair_phase_q) begin
          low_half_d   = byte_i;
          pair_phase_d = 1'b1;
        end else begin
          pair_phase_d = 1'b0;
          if (idx == AppearIdx) begin
            app_pending_d = pair_val;
            cm_app        = pair_val;
          end
          if (pair_val == cfg_i.svc_uuid) begin
            uuid_pending_d = 1'b1;
            cm_uuid        = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (commit) begin
      if (cm_type == cfg_i.appearance_type && struct_len_q >= AppearMinLen &&
          !app_seen_q) begin
        app_result_d = cm_app;
        app_seen_d   = 1'b1;
      end
      if (cm_uuid && (cm_type == cfg_i.list_type_a || cm_type == cfg_i.list_type_b)) begin
        uuid_result_d = 1'b1;
      end
    end
  end

  // result as seen after this byte, valid only when last_i is set
  assign res_o.appearance = app_seen_d ? app_result_d : 16'd0;
  assign res_o.uuid_found = uuid_result_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhLen;
      bytes_left_q   <= 8'd0;
      struct_len_q   <= 8'd0;
      struct_type_q  <= 8'd0;
      low_half_q     <= 8'd0;
      pair_phase_q   <= 1'b0;
      app_pending_q  <= 16'd0;
      app_result_q   <= 16'd0;
      app_seen_q     <= 1'b0;
      uuid_pending_q <= 1'b0;
      uuid_result_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      if (last_i) begin
        bytes_left_q   <= 8'd0;
        struct_len_q   <= 8'd0;
        struct_type_q  <= 8'd0;
        low_half_q     <= 8'd0;
        pair_phase_q   <= 1'b0;
        app_pending_q  <= 16'd0;
        app_result_q   <= 16'd0;
        app_seen_q     <= 1'b0;
        uuid_pending_q <= 1'b0;
        uuid_result_q  <= 1'b0;
      end else begin
        bytes_left_q   <= bytes_left_d;
        struct_len_q   <= struct_len_d;
        struct_type_q  <= struct_type_d;
        low_half_q     <= low_half_d;
        pair_phase_q   <= pair_phase_d;
        app_pending_q  <= app_pending_d;
        app_result_q   <= app_result_d;
        app_seen_q     <= app_seen_d;
        uuid_pending_q <= uuid_pending_d;
        uuid_result_q  <= uuid_result_d;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PhLen && !uuid_result_q && !app_seen_q)
    else $error("packet state not cleared after last byte");

  a_app_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !app_seen_q |-> app_result_q == 16'd0)
    else $error("appearance held without a complete structure");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> bytes_left_q != 8'd0)
    else $error("data phase with no bytes owed");

endmodule
